### rtl/bcpb_pkg.sv
package bcpb_pkg;

    // Field widths fixed by the stream format
    localparam int CELL_W  = 16;
    localparam int FACE_W  = 3;
    localparam int NBR_W   = 17;
    localparam int NUM_NBR = 6;
    localparam int POS_W   = 21;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 2;

    typedef logic [NBR_W-1:0]  t_nbr;
    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [POS_W-1:0]  t_word;
    typedef logic [KIND_W-1:0] t_kind;

    // Result kinds
    localparam t_kind KIND_ROWPTR = 2'd0;
    localparam t_kind KIND_COLIDX = 2'd1;
    localparam t_kind KIND_TOTAL  = 2'd2;

    // Controller -> datapath commands
    typedef struct packed {
        logic  load;     // capture accepted item, seed list with own cell
        logic  insert;   // insert selected neighbor into sorted list
        logic  push;     // write one result into the output register
        t_kind kind;
        logic  blk_row;  // block row j
        logic  blk_col;  // block column l
        logic  last;     // last result of this item
    } t_dp_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic              space;      // output register can take a result
        logic              b2;         // two blocks per dimension
        logic              last_cell;
        logic [FACE_W-1:0] faces;      // saturated face count
    } t_dp_sts;

endpackage

### rtl/bcpb_ctrl.sv
module bcpb_ctrl
    import bcpb_pkg::*;
#(
    parameter int IDX_W = 3,
    parameter int CNT_W = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_fire,
    input  t_dp_sts           i_sts,
    input  logic [CNT_W-1:0]  i_col_count,
    output logic              o_idle,
    output t_dp_cmd           o_cmd,
    output logic [FACE_W-1:0] o_face_sel,
    output logic [IDX_W-1:0]  o_col_sel
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SORT = 3'd1;
    localparam logic [2:0] ST_ROW  = 3'd2;
    localparam logic [2:0] ST_COL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [FACE_W-1:0] r_face,  n_face;
    logic [IDX_W-1:0]  r_i,     n_i;
    logic              r_j,     n_j;
    logic              r_l,     n_l;
    logic              l_end;
    logic              i_end;

    assign o_idle     = (r_state == ST_IDLE);
    assign o_face_sel = r_face;
    assign o_col_sel  = r_i;

    assign l_end = !i_sts.b2 || r_l;
    assign i_end = ((CNT_W'(r_i) + CNT_W'(1)) == i_col_count);

    always_comb begin
        n_state = r_state;
        n_face  = r_face;
        n_i     = r_i;
        n_j     = r_j;
        n_l     = r_l;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_face     = '0;
                    n_j        = 1'b0;
                    n_state    = ST_SORT;
                end
            end
            ST_SORT: begin
                if (r_face == i_sts.faces) begin
                    n_state = ST_ROW;
                end else begin
                    o_cmd.insert = 1'b1;
                    n_face       = r_face + FACE_W'(1);
                end
            end
            ST_ROW: begin
                if (i_sts.space) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.kind    = KIND_ROWPTR;
                    o_cmd.blk_row = r_j;
                    n_i           = '0;
                    n_l           = 1'b0;
                    n_state       = ST_COL;
                end
            end
            ST_COL: begin
                if (i_sts.space) begin
                    o_cmd.push    = 1'b1;
                    o_cmd.kind    = KIND_COLIDX;
                    o_cmd.blk_col = r_l;
                    if (l_end) begin
                        n_l = 1'b0;
                        if (i_end) begin
                            if (i_sts.b2 && !r_j) begin
                                n_j     = 1'b1;
                                n_state = ST_ROW;
                            end else if (i_sts.last_cell) begin
                                n_state = ST_FIN;
                            end else begin
                                o_cmd.last = 1'b1;
                                n_state    = ST_IDLE;
                            end
                        end else begin
                            n_i = r_i + IDX_W'(1);
                        end
                    end else begin
                        n_l = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (i_sts.space) begin
                    o_cmd.push = 1'b1;
                    o_cmd.kind = KIND_TOTAL;
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_face  <= '0;
            r_i     <= '0;
            r_j     <= 1'b0;
            r_l     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_face  <= n_face;
            r_i     <= n_i;
            r_j     <= n_j;
            r_l     <= n_l;
        end
    end

endmodule

### rtl/bcpb_dp.sv
module bcpb_dp
    import bcpb_pkg::*;
#(
    parameter int MAX_FACES = 6,
    parameter int MAX_CELLS = 65536,
    parameter int NSLOTS    = 7,
    parameter int IDX_W     = 3,
    parameter int CNT_W     = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  t_cell             i_cell,
    input  logic [FACE_W-1:0] i_faces,
    input  t_nbr              i_nbr [NUM_NBR],
    input  logic              i_last_cell,
    input  t_dp_cmd           i_cmd,
    input  logic [FACE_W-1:0] i_face_sel,
    input  logic [IDX_W-1:0]  i_col_sel,
    input  logic              i_out_ready,
    output t_dp_sts           o_sts,
    output logic [CNT_W-1:0]  o_col_count,
    output logic              o_out_valid,
    output t_kind             o_out_kind,
    output t_word             o_out_pos,
    output t_word             o_out_val,
    output logic              o_out_last
);

    localparam logic [NBR_W-1:0]  NB_LIMIT = NBR_W'(MAX_CELLS);
    localparam logic [FACE_W-1:0] FACE_MAX = FACE_W'(MAX_FACES);

    logic [CFG_W-1:0]  r_cfg;
    t_word             r_offset;
    t_cell             r_cell;
    logic [FACE_W-1:0] r_faces;
    logic              r_last_cell;
    t_nbr              r_nbr [NUM_NBR];
    t_cell             r_cols [NSLOTS];
    logic [CNT_W-1:0]  r_cnt;

    logic              r_valid;
    t_kind             r_kind;
    t_word             r_pos;
    t_word             r_val;
    logic              r_last;

    logic              b2;
    logic              space;
    t_nbr              nb;
    logic              nb_ok;
    logic [NSLOTS-1:0] keep;
    t_cell             ins_cols [NSLOTS];
    t_cell             col;
    t_word             n_pos;
    t_word             n_val;

    // blocks 0 and 1 act as one, 3 saturates to 2
    assign b2    = r_cfg[1];
    assign space = !r_valid || i_out_ready;

    assign o_sts.space     = space;
    assign o_sts.b2        = b2;
    assign o_sts.last_cell = r_last_cell;
    assign o_sts.faces     = r_faces;
    assign o_col_count     = r_cnt;

    // parallel insertion: entries above the new value move up one slot
    assign nb    = r_nbr[i_face_sel];
    assign nb_ok = !nb[NBR_W-1] && (nb < NB_LIMIT);

    always_comb begin
        for (int k = 0; k < NSLOTS; k++) begin
            keep[k] = (CNT_W'(k) < r_cnt) && !(r_cols[k] > nb[CELL_W-1:0]);
        end
        ins_cols[0] = keep[0] ? r_cols[0] : nb[CELL_W-1:0];
        for (int k = 1; k < NSLOTS; k++) begin
            if (keep[k]) begin
                ins_cols[k] = r_cols[k];
            end else if (keep[k-1]) begin
                ins_cols[k] = nb[CELL_W-1:0];
            end else begin
                ins_cols[k] = r_cols[k-1];
            end
        end
    end

    assign col = r_cols[i_col_sel];

    always_comb begin
        case (i_cmd.kind)
            KIND_ROWPTR: begin
                n_pos = b2 ? POS_W'({r_cell, i_cmd.blk_row}) : POS_W'(r_cell);
                n_val = r_offset;
            end
            KIND_COLIDX: begin
                n_pos = r_offset;
                n_val = b2 ? POS_W'({col, i_cmd.blk_col}) : POS_W'(col);
            end
            KIND_TOTAL: begin
                n_pos = b2 ? POS_W'({{1'b0, r_cell} + 17'd1, 1'b0})
                           : POS_W'({1'b0, r_cell} + 17'd1);
                n_val = r_offset;
            end
            default: begin
                n_pos = '0;
                n_val = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= CFG_W'(1);
            r_offset <= '0;
            r_cnt    <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_cnt <= CNT_W'(1);
            end else if (i_cmd.insert && nb_ok) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.push && i_cmd.kind == KIND_COLIDX) begin
                r_offset <= r_offset + POS_W'(1);
            end else if (i_cmd.push && i_cmd.kind == KIND_TOTAL) begin
                r_offset <= '0;
            end
            if (i_cmd.push) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cell      <= i_cell;
            r_faces     <= (i_faces > FACE_MAX) ? FACE_MAX : i_faces;
            r_last_cell <= i_last_cell;
            r_nbr       <= i_nbr;
            r_cols[0]   <= i_cell;
        end else if (i_cmd.insert && nb_ok) begin
            r_cols <= ins_cols;
        end
        if (i_cmd.push) begin
            r_kind <= i_cmd.kind;
            r_pos  <= n_pos;
            r_val  <= n_val;
            r_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_kind  = r_kind;
    assign o_out_pos   = r_pos;
    assign o_out_val   = r_val;
    assign o_out_last  = r_last;

endmodule

### rtl/block_csr_pattern_builder_unit.sv
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid tready tdata tlast     one mesh cell, tlast = last cell
// m_axis    out  tvalid tready tdata tuser tlast  one CSR entry, tlast = last of cell
// cfg       in   i_cfg_wr_en i_cfg_wr_data      blocks per dimension
//
// Flow: one item is accepted in idle, then one insertion step per face (F =
//   saturated face count) through the sorted list, then R results (B*(1+N*B), plus
//   a final total after the last cell), one result per cycle while not stalled.
// A new item is taken only in idle; the output register may still hold the last
//   result of the previous item while the next one is accepted.
// Reset: synchronous, active low; clears state machine, offset, blocks = 1.
// Stalls: m_axis_tready low holds the output register and freezes emission.
module block_csr_pattern_builder_unit
    import bcpb_pkg::*;
#(
    parameter int MAX_FACES = 6,
    parameter int MAX_CELLS = 65536
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write, no read-back
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_wr_data,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [15:0] cell_index, [18:16] face_count, [35:19] neighbor_0,
    // [52:36] neighbor_1, [69:53] neighbor_2, [86:70] neighbor_3,
    // [103:87] neighbor_4, [120:104] neighbor_5, [127:121] zero
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tlast,   // last_cell
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [20:0] position, [41:21] value, [47:42] zero
    output logic [47:0]  m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] entry_kind
    output logic         m_axis_tlast    // last result of the item
);

    // sorted list holds the cell itself plus up to MAX_FACES neighbors
    localparam int NSLOTS = MAX_FACES + 1;
    localparam int IDX_W  = $clog2(NSLOTS);
    localparam int CNT_W  = $clog2(NSLOTS + 1);

    localparam int NBR_LO = CELL_W + FACE_W;

    logic              in_fire;
    logic              idle;
    t_dp_cmd           cmd;
    t_dp_sts           sts;
    logic [FACE_W-1:0] face_sel;
    logic [IDX_W-1:0]  col_sel;
    logic [CNT_W-1:0]  col_count;
    t_nbr              nbr [NUM_NBR];
    t_word             out_pos;
    t_word             out_val;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = idle;

    always_comb begin
        for (int k = 0; k < NUM_NBR; k++) begin
            nbr[k] = s_axis_tdata[NBR_LO + k*NBR_W +: NBR_W];
        end
    end

    bcpb_ctrl #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_sts       (sts),
        .i_col_count (col_count),
        .o_idle      (idle),
        .o_cmd       (cmd),
        .o_face_sel  (face_sel),
        .o_col_sel   (col_sel)
    );

    bcpb_dp #(
        .MAX_FACES (MAX_FACES),
        .MAX_CELLS (MAX_CELLS),
        .NSLOTS    (NSLOTS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_wr_en),
        .i_cfg_wdata (i_cfg_wr_data),
        .i_cell      (s_axis_tdata[CELL_W-1:0]),
        .i_faces     (s_axis_tdata[CELL_W +: FACE_W]),
        .i_nbr       (nbr),
        .i_last_cell (s_axis_tlast),
        .i_cmd       (cmd),
        .i_face_sel  (face_sel),
        .i_col_sel   (col_sel),
        .i_out_ready (m_axis_tready),
        .o_sts       (sts),
        .o_col_count (col_count),
        .o_out_valid (m_axis_tvalid),
        .o_out_kind  (m_axis_tuser),
        .o_out_pos   (out_pos),
        .o_out_val   (out_val),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, out_val, out_pos};

    // one item at a time: accepting drops ready on the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input accepted while previous item in flight");

    // the final total always closes the item
    a_total_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_TOTAL) |-> m_axis_tlast)
        else $error("final total without tlast");

    // a row pointer is never the last result of an item
    a_rowptr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_ROWPTR) |-> !m_axis_tlast)
        else $error("row pointer flagged last");

    // no push while the output register is full and stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !cmd.push)
        else $error("result pushed into stalled output register");

endmodule
